// File: src/ffba_pkg.sv
package ffba_pkg;
    localparam int MEM_BYTES  = 16384;
    localparam int HDR_BYTES  = 16;
    localparam int MAX_BLOCKS = 64;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SIZE_W = $clog2(MEM_BYTES);
    localparam int OFS_W  = 14;
    localparam int ST_W   = 2;
    // wide enough for offsets, sizes plus headers and requests at any legal arena size
    localparam int CW     = 18;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BADADDR = 2'd2;

    localparam logic [CW-1:0]     HDR_W  = CW'(HDR_BYTES);
    localparam logic [SIZE_W-1:0] SIZE0  = SIZE_W'(MEM_BYTES - HDR_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_tbl_req;
endpackage

// File: src/first_fit_block_allocator_top.sv
// Each request walks the table entry by entry; a split moves later entries up by one
// and a merge moves them down, through the single table memory port.
// Throughput: one request at a time; the table memory port sets the pace.
// Reset (synchronous, active low) leaves one free block covering the arena and
// writes the first table entry in S_INIT before s_axis_tready rises.
module first_fit_block_allocator_top import ffba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [13:0] request_size, [27:14] release_offset
    input  logic        s_axis_tuser,  // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [13:0] payload_offset
    output logic [1:0]  m_axis_tuser   // [1:0] status
);
    t_tbl_req         w_tbl;
    t_entry           w_rdata;
    logic [OFS_W-1:0] w_ofs;

    ffba_table u_table (
        .i_clk   (i_clk),
        .i_req   (w_tbl),
        .o_rdata (w_rdata)
    );

    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_mode     (s_axis_tuser),
        .i_req_size (s_axis_tdata[13:0]),
        .i_rel_ofs  (s_axis_tdata[27:14]),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_ofs      (w_ofs),
        .o_status   (m_axis_tuser),
        .o_tbl      (w_tbl),
        .i_rdata    (w_rdata)
    );

    assign m_axis_tdata = {2'b00, w_ofs};

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NOSPACE
                           || m_axis_tuser == ST_BADADDR))
        else $error("unknown status code");

    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("offset given with a failed request");

    a_offset_past_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata != '0) |-> (m_axis_tdata >= 16'(HDR_BYTES)
                                                   || MEM_BYTES > 16384))
        else $error("granted offset inside first header");
endmodule

// File: src/ffba_table.sv
module ffba_table import ffba_pkg::*; (
    input  logic     i_clk,
    input  t_tbl_req i_req,
    output t_entry   o_rdata
);
    t_entry r_mem [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

// File: src/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic [OFS_W-1:0]  i_req_size,
    input  logic [OFS_W-1:0]  i_rel_ofs,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OFS_W-1:0]  o_ofs,
    output logic [ST_W-1:0]   o_status,
    output t_tbl_req          o_tbl,
    input  t_entry            i_rdata
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ARD, S_AEV, S_SHR, S_SHW, S_SPL, S_SPL2,
        S_RRD, S_REV, S_RNR, S_RNX, S_MRG, S_SLR, S_SLW, S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt, r_i, r_k;
    logic [1:0]        r_n;
    logic [CW-1:0]     r_base, r_req, r_rel;
    logic [SIZE_W-1:0] r_fsize, r_csize, r_psize, r_nsize;
    logic              r_pfree, r_nfree;
    logic [OFS_W-1:0]  r_res_ofs;
    logic [ST_W-1:0]   r_res_st;

    logic [CW-1:0] w_dsize, w_next_base, w_hit_ofs;
    logic [CNT_W-1:0] w_i1;
    logic w_pf;

    assign w_dsize     = CW'(i_rdata.size);
    assign w_next_base = r_base + HDR_W + w_dsize;
    assign w_hit_ofs   = r_base + HDR_W;
    assign w_i1        = r_i + 1'b1;
    assign w_pf        = (r_i != '0) && r_pfree;
    assign o_ready     = (r_state == S_IDLE);

    always_comb begin
        o_tbl = '0;
        case (r_state)
            S_INIT: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = '0;
                o_tbl.wdata = '{free: 1'b1, size: SIZE0};
            end
            S_ARD, S_RRD: o_tbl.raddr = r_i[IDX_W-1:0];
            S_AEV: begin
                o_tbl.raddr = r_i[IDX_W-1:0];
                if (i_rdata.free && w_dsize == r_req) begin
                    o_tbl.we    = 1'b1;
                    o_tbl.waddr = r_i[IDX_W-1:0];
                    o_tbl.wdata = '{free: 1'b0, size: r_req[SIZE_W-1:0]};
                end
            end
            S_SHR: o_tbl.raddr = IDX_W'(r_k - 1'b1);
            S_SHW: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = r_k[IDX_W-1:0];
                o_tbl.wdata = i_rdata;
            end
            S_SPL: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = w_i1[IDX_W-1:0];
                o_tbl.wdata = '{free: 1'b1,
                                size: SIZE_W'(CW'(r_fsize) - r_req - HDR_W)};
            end
            S_SPL2: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = r_i[IDX_W-1:0];
                o_tbl.wdata = '{free: 1'b0, size: r_req[SIZE_W-1:0]};
            end
            S_RNR: o_tbl.raddr = w_i1[IDX_W-1:0];
            S_MRG: begin
                o_tbl.we = 1'b1;
                if (w_pf) begin
                    o_tbl.waddr = IDX_W'(r_i - 1'b1);
                    o_tbl.wdata = '{free: 1'b1, size: SIZE_W'(CW'(r_psize) + HDR_W
                        + CW'(r_csize) + (r_nfree ? HDR_W + CW'(r_nsize) : '0))};
                end else begin
                    o_tbl.waddr = r_i[IDX_W-1:0];
                    o_tbl.wdata = '{free: 1'b1, size: SIZE_W'(CW'(r_csize)
                        + (r_nfree ? HDR_W + CW'(r_nsize) : '0))};
                end
            end
            S_SLR: o_tbl.raddr = IDX_W'(r_k + CNT_W'(r_n));
            S_SLW: begin
                o_tbl.we    = 1'b1;
                o_tbl.waddr = r_k[IDX_W-1:0];
                o_tbl.wdata = i_rdata;
            end
            default: o_tbl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= CNT_W'(1);
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_valid) begin
                        r_i       <= '0;
                        r_base    <= '0;
                        r_pfree   <= 1'b0;
                        r_req     <= CW'(i_req_size);
                        r_rel     <= CW'(i_rel_ofs);
                        r_res_ofs <= '0;
                        r_res_st  <= ST_OK;
                        r_state   <= i_mode ? S_RRD : S_ARD;
                    end
                end
                S_ARD: r_state <= S_AEV;
                S_AEV: begin
                    if (i_rdata.free && w_dsize >= r_req) begin
                        r_fsize <= i_rdata.size;
                        r_k     <= r_cnt;
                        if (w_dsize == r_req) begin
                            r_res_ofs <= w_hit_ofs[OFS_W-1:0];
                            r_state   <= S_DONE;
                        end else if (w_dsize > r_req + HDR_W && r_cnt != CNT_MAX) begin
                            r_state <= (r_cnt > w_i1) ? S_SHR : S_SPL;
                        end else begin
                            r_res_st <= ST_NOSPACE;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_base <= w_next_base;
                        r_i    <= w_i1;
                        if (w_i1 == r_cnt) begin
                            r_res_st <= ST_NOSPACE;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_ARD;
                        end
                    end
                end
                S_SHR: r_state <= S_SHW;
                S_SHW: begin
                    r_k     <= r_k - 1'b1;
                    r_state <= (r_k - 1'b1 > w_i1) ? S_SHR : S_SPL;
                end
                S_SPL: r_state <= S_SPL2;
                S_SPL2: begin
                    r_cnt     <= r_cnt + 1'b1;
                    r_res_ofs <= w_hit_ofs[OFS_W-1:0];
                    r_state   <= S_DONE;
                end
                S_RRD: r_state <= S_REV;
                S_REV: begin
                    if (w_hit_ofs == r_rel) begin
                        r_csize <= i_rdata.size;
                        r_nfree <= 1'b0;
                        if (i_rdata.free) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= (w_i1 < r_cnt) ? S_RNR : S_MRG;
                        end
                    end else begin
                        r_base  <= w_next_base;
                        r_pfree <= i_rdata.free;
                        r_psize <= i_rdata.size;
                        r_i     <= w_i1;
                        if (w_i1 == r_cnt) begin
                            r_res_st <= ST_BADADDR;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_RRD;
                        end
                    end
                end
                S_RNR: r_state <= S_RNX;
                S_RNX: begin
                    r_nfree <= i_rdata.free;
                    r_nsize <= i_rdata.size;
                    r_state <= S_MRG;
                end
                S_MRG: begin
                    // close the gap left by the merged neighbors
                    r_k <= w_pf ? r_i : w_i1;
                    r_n <= {1'b0, w_pf} + {1'b0, r_nfree};
                    if (!w_pf && !r_nfree) begin
                        r_state <= S_DONE;
                    end else if ((w_pf ? r_i : w_i1) + CNT_W'({1'b0, w_pf} + {1'b0, r_nfree})
                                 < r_cnt) begin
                        r_state <= S_SLR;
                    end else begin
                        r_cnt   <= r_cnt - CNT_W'({1'b0, w_pf} + {1'b0, r_nfree});
                        r_state <= S_DONE;
                    end
                end
                S_SLR: r_state <= S_SLW;
                S_SLW: begin
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 + CNT_W'(r_n) < r_cnt) begin
                        r_state <= S_SLR;
                    end else begin
                        r_cnt   <= r_cnt - CNT_W'(r_n);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid  <= 1'b1;
                        o_ofs    <= r_res_ofs;
                        o_status <= r_res_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: dv/tb.sv
module tb import ffba_pkg::*;;

    typedef struct {
        bit          rel;
        logic [13:0] req_size;
        logic [13:0] rel_ofs;
        bit          known;
        logic [13:0] exp_ofs;
        logic [1:0]  exp_st;
    } t_row;

    typedef struct {
        logic [13:0] ofs;
        logic [1:0]  st;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [13:0] request_size, [27:14] release_offset
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [13:0] payload_offset
    logic [1:0]  m_axis_tuser;   // [1:0] status

    first_fit_block_allocator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // allocator shadow table
    int unsigned sh_size [MAX_BLOCKS];
    bit          sh_free [MAX_BLOCKS];
    int unsigned sh_count;

    t_grant      pending[$];
    int          errors;
    int          n_alloc, n_rel, n_grant, n_nospace, n_badaddr;
    int          cycles;
    int          send_idle, recv_idle;

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void shadow_reset();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            sh_size[k] = 0;
            sh_free[k] = 0;
        end
        sh_size[0] = MEM_BYTES - HDR_BYTES;
        sh_free[0] = 1;
        sh_count = 1;
    endfunction

    function automatic void merge_free_runs();
        int unsigned i;
        i = 0;
        while (i + 1 < sh_count) begin
            if (sh_free[i] && sh_free[i+1]) begin
                sh_size[i] += HDR_BYTES + sh_size[i+1];
                for (int unsigned k = i + 1; k + 1 < sh_count; k++) begin
                    sh_size[k] = sh_size[k+1];
                    sh_free[k] = sh_free[k+1];
                end
                sh_count--;
                sh_size[sh_count] = 0;
                sh_free[sh_count] = 0;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic t_grant predict_grant(input bit rel, input int unsigned req,
                                             input int unsigned ofs);
        t_grant g;
        int unsigned base;
        int unsigned i;
        g.ofs = '0;
        g.st  = ST_OK;
        base  = 0;
        if (!rel) begin
            for (i = 0; i < sh_count; i++) begin
                if (sh_free[i] && sh_size[i] >= req) break;
                base += HDR_BYTES + sh_size[i];
            end
            if (i >= sh_count) begin
                g.st = ST_NOSPACE;
                return g;
            end
            if (sh_size[i] == req) begin
                sh_free[i] = 0;
            end else if (sh_size[i] > req + HDR_BYTES) begin
                if (sh_count >= MAX_BLOCKS) begin
                    g.st = ST_NOSPACE;
                    return g;
                end
                for (int unsigned k = sh_count; k > i + 1; k--) begin
                    sh_size[k] = sh_size[k-1];
                    sh_free[k] = sh_free[k-1];
                end
                sh_size[i+1] = sh_size[i] - req - HDR_BYTES;
                sh_free[i+1] = 1;
                sh_size[i] = req;
                sh_free[i] = 0;
                sh_count++;
            end else begin
                g.st = ST_NOSPACE;
                return g;
            end
            g.ofs = 14'(base + HDR_BYTES);
            return g;
        end
        for (i = 0; i < sh_count; i++) begin
            if (base + HDR_BYTES == ofs) begin
                sh_free[i] = 1;
                merge_free_runs();
                return g;
            end
            base += HDR_BYTES + sh_size[i];
        end
        g.st = ST_BADADDR;
        return g;
    endfunction

    // payload start of a random existing block: used only when used_only is set, else used or free
    function automatic int unsigned pick_block_ofs(input bit used_only);
        int unsigned base;
        int unsigned cand[$];
        base = 0;
        for (int unsigned i = 0; i < sh_count; i++) begin
            if (!used_only || !sh_free[i]) cand.push_back(base + HDR_BYTES);
            base += HDR_BYTES + sh_size[i];
        end
        if (cand.size() == 0) return HDR_BYTES;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_request(input t_row r);
        t_grant g;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.rel;
        s_axis_tdata  <= {4'b0, r.rel_ofs, r.req_size};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        g = predict_grant(r.rel, r.req_size, r.rel_ofs);
        if (r.known && (g.ofs !== r.exp_ofs || g.st !== r.exp_st))
            report("table row vs predictor status", g.st, r.exp_st);
        pending.push_back(g);
        if (r.rel) n_rel++; else n_alloc++;
        @(negedge i_clk);
    endtask

    // result side
    always @(posedge i_clk) begin
        t_grant w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                report("unexpected result, status", m_axis_tuser, -1);
            end else begin
                w = pending.pop_front();
                if (m_axis_tdata[13:0] !== w.ofs)
                    report("payload_offset", m_axis_tdata[13:0], w.ofs);
                if (m_axis_tuser !== w.st)
                    report("status", m_axis_tuser, w.st);
                if (w.st == ST_NOSPACE) n_nospace++;
                if (w.st == ST_BADADDR) n_badaddr++;
                if (w.st == ST_OK && w.ofs != 0) n_grant++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (recv_idle > 0 && $urandom_range(99) < recv_idle) m_axis_tready <= 1'b0;
        else m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_row mk(input bit rel, input int unsigned req, input int unsigned ofs,
                                input bit known, input int unsigned eofs,
                                input logic [1:0] est);
        t_row r;
        r.rel = rel;
        r.req_size = 14'(req);
        r.rel_ofs = 14'(ofs);
        r.known = known;
        r.exp_ofs = 14'(eofs);
        r.exp_st = est;
        return r;
    endfunction

    initial begin
        t_row dir[$];
        t_row r;
        int unsigned sel;
        int unsigned n;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle = 21;
        recv_idle = 48;
        shadow_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, split, exact match, awkward fit, bad and free releases
        dir.push_back(mk(0, 16383, 0, 1, 0, ST_NOSPACE));        // no fitting block
        dir.push_back(mk(1, 0, 0, 1, 0, ST_BADADDR));            // bad address
        dir.push_back(mk(1, 0, 16383, 1, 0, ST_BADADDR));
        dir.push_back(mk(1, 0, 16, 1, 0, ST_OK));                // release of free block
        dir.push_back(mk(0, 0, 0, 1, 16, ST_OK));                // zero request split
        dir.push_back(mk(0, 100, 0, 1, 32, ST_OK));
        dir.push_back(mk(0, 200, 0, 0, 0, ST_OK));
        dir.push_back(mk(1, 0, 32, 1, 0, ST_OK));
        dir.push_back(mk(0, 100, 0, 1, 32, ST_OK));              // exact match
        dir.push_back(mk(1, 0, 32, 1, 0, ST_OK));
        dir.push_back(mk(0, 90, 0, 1, 0, ST_NOSPACE));           // awkward fit
        dir.push_back(mk(1, 0, 148, 0, 0, ST_OK));               // chained merge
        dir.push_back(mk(1, 0, 16, 0, 0, ST_OK));
        dir.push_back(mk(0, 16368, 0, 1, 16, ST_OK));            // whole arena exact
        dir.push_back(mk(0, 0, 0, 1, 0, ST_NOSPACE));
        dir.push_back(mk(1, 0, 16, 1, 0, ST_OK));
        dir.push_back(mk(1, 1, 16, 1, 0, ST_OK));                // mode bit with stray size
        foreach (dir[k]) send_request(dir[k]);

        // random: mixed allocate and release churn; three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle = 48; recv_idle = 21; end
            if (ph == 2) begin send_idle = 0;  recv_idle = 0;  end
            n = (ph == 2) ? 640 : 600;
            for (int unsigned j = 0; j < n; j++) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    if ($urandom_range(3) == 0)
                        r = mk(0, $urandom_range(16383), 0, 0, 0, ST_OK);
                    else
                        r = mk(0, $urandom_range(300), $urandom_range(16383), 0, 0, ST_OK);
                end else if (sel < 85) begin
                    r = mk(1, $urandom_range(16383), pick_block_ofs(sel < 75), 0, 0, ST_OK);
                end else if (sel < 95) begin
                    r = mk(1, 0, $urandom_range(16383), 0, 0, ST_OK);
                end else begin
                    // exact size of some existing block, used or free
                    r = mk(0, sh_size[$urandom_range(sh_count - 1)], 0, 0, 0, ST_OK);
                end
                send_request(r);
            end
            s_axis_tvalid <= 1'b0;
            while (pending.size() != 0) @(posedge i_clk);
        end
        repeat (300) @(posedge i_clk);
        $display("covered %0d allocate and %0d release requests", n_alloc, n_rel);
        $display("grants %0d, no-space %0d, bad-address %0d",
                 n_grant, n_nospace, n_badaddr);
        if (errors == 0 && pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// File: first_fit_block_allocator_top.f
src/ffba_pkg.sv
src/ffba_table.sv
src/ffba_ctrl.sv
src/first_fit_block_allocator_top.sv
dv/tb.sv
